// File: rtl/colormap_interpolation_lut_top_macros.svh
// Assertion macros shared by the colour map lookup checker.
`ifndef COLORMAP_INTERPOLATION_LUT_TOP_MACROS_SVH
`define COLORMAP_INTERPOLATION_LUT_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CLI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CLI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cli_pkg.sv
// Shared constants and types of the colour map lookup.
`timescale 1ns / 1ps
package cli_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
    localparam int STEP_DIV      = TABLE_ENTRIES - 1;
    localparam int CH_W          = 16;
    localparam int FULL_SCALE    = (1 << CH_W) - 1;
    localparam int NUM_CH        = 3;
    localparam int POINT_W       = NUM_CH * CH_W;
    localparam int OUT_W         = 8;
    localparam int SLOT_W        = 6;
    localparam int CFG_W         = 7;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic valid;
        logic lookup;
        logic wr_ok;
    } t_cli_ctl;

endpackage

// File: rtl/cli_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cli_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cli_index.sv
// Front stages: entry position in the point table and the split by 255.
`timescale 1ns / 1ps
module cli_index import cli_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_func,
    input  logic [SLOT_W-1:0]             i_slot,
    input  logic [POINT_W-1:0]            i_point,
    input  logic [ENTRY_W-1:0]            i_entry,
    input  logic [$clog2(MAX_POINTS)-1:0] i_last,
    input  logic                          i_next_en,
    output logic                          o_ready,
    output t_cli_ctl                      o_ctl,
    output logic [$clog2(MAX_POINTS)-1:0] o_left,
    output logic [$clog2(MAX_POINTS)-1:0] o_right,
    output logic [ENTRY_W-1:0]            o_frac,
    output logic [$clog2(MAX_POINTS)-1:0] o_waddr,
    output logic [POINT_W-1:0]            o_point
);

    localparam int LW = $clog2(MAX_POINTS);
    localparam int PW = ENTRY_W + LW;
    localparam int RW = ENTRY_W + 2;

    t_cli_ctl             r_ctl1, r_ctl2, n_ctl1;
    logic [PW-1:0]        r_pos1;
    logic [SLOT_W-1:0]    r_slot1;
    logic [POINT_W-1:0]   r_point1, r_point2;
    logic [LW-1:0]        r_left2, r_right2, r_waddr2;
    logic [ENTRY_W-1:0]   r_frac2;
    logic                 w_en1, w_en2;
    logic [LW-1:0]        w_q0, w_left, w_right;
    logic [RW-1:0]        w_rem0;
    logic [ENTRY_W-1:0]   w_frac;

    assign w_en2   = !r_ctl2.valid || i_next_en;
    assign w_en1   = !r_ctl1.valid || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        n_ctl1.valid  = i_valid;
        n_ctl1.lookup = (i_func == FUNC_LOOKUP);
        n_ctl1.wr_ok  = ({{(32-SLOT_W){1'b0}}, i_slot} < 32'(MAX_POINTS));
    end

    // Stage 1: position of the entry along the point table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (w_en1) begin
            r_ctl1 <= n_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_pos1   <= PW'(i_entry) * PW'(i_last);
            r_slot1  <= i_slot;
            r_point1 <= i_point;
        end
    end

    // Division by 255: the shifted estimate is low by at most two.
    always_comb begin
        w_q0   = r_pos1[PW-1:ENTRY_W];
        w_rem0 = RW'(r_pos1[ENTRY_W-1:0]) + RW'(w_q0);
        if (w_rem0 >= RW'(2 * STEP_DIV)) begin
            w_left = w_q0 + LW'(2);
            w_frac = ENTRY_W'(w_rem0 - RW'(2 * STEP_DIV));
        end else if (w_rem0 >= RW'(STEP_DIV)) begin
            w_left = w_q0 + LW'(1);
            w_frac = ENTRY_W'(w_rem0 - RW'(STEP_DIV));
        end else begin
            w_left = w_q0;
            w_frac = ENTRY_W'(w_rem0);
        end
        w_right = (w_frac != '0) ? (w_left + LW'(1)) : w_left;
    end

    // Stage 2: point addresses and blend fraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (w_en2) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_left2  <= w_left;
            r_right2 <= w_right;
            r_frac2  <= w_frac;
            r_waddr2 <= LW'(r_slot1);
            r_point2 <= r_point1;
        end
    end

    assign o_ctl   = r_ctl2;
    assign o_left  = r_left2;
    assign o_right = r_right2;
    assign o_frac  = r_frac2;
    assign o_waddr = r_waddr2;
    assign o_point = r_point2;

endmodule

// File: rtl/cli_blend.sv
// Back stages: weighted sum of two points per channel and scaling to eight bits.
`timescale 1ns / 1ps
module cli_blend import cli_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [POINT_W-1:0]      i_y0,
    input  logic [POINT_W-1:0]      i_y1,
    input  logic [ENTRY_W-1:0]      i_frac,
    input  logic                    i_tready,
    output logic                    o_take,
    output logic                    o_tvalid,
    output logic [NUM_CH*OUT_W-1:0] o_tdata
);

    localparam int PRW = ENTRY_W + CH_W;
    localparam int SW  = PRW + 1;
    localparam int QW  = SW - CH_W;

    logic                    r_v4, r_v5;
    logic [PRW-1:0]          r_p0 [NUM_CH];
    logic [PRW-1:0]          r_p1 [NUM_CH];
    logic [NUM_CH*OUT_W-1:0] r_out;
    logic [NUM_CH*OUT_W-1:0] w_out;
    logic [SW-1:0]           w_sum [NUM_CH];
    logic [QW-1:0]           w_q   [NUM_CH];
    logic [CH_W:0]           w_rem [NUM_CH];
    logic                    w_en4, w_en5;

    assign w_en5  = !r_v5 || i_tready;
    assign w_en4  = !r_v4 || w_en5;
    assign o_take = w_en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en4) begin
                r_v4 <= i_valid;
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Stage 4: the two weighted terms of each channel.
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_p0[c] <= PRW'(ENTRY_W'(STEP_DIV) - i_frac) * PRW'(i_y0[c*CH_W +: CH_W]);
                r_p1[c] <= PRW'(i_frac) * PRW'(i_y1[c*CH_W +: CH_W]);
            end
        end
    end

    // Division by 65535: the shifted estimate is low by at most one.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_sum[c] = SW'(r_p0[c]) + SW'(r_p1[c]);
            w_rem[c] = (CH_W+1)'(w_sum[c][CH_W-1:0]) + (CH_W+1)'(w_sum[c][SW-1:CH_W]);
            w_q[c]   = w_sum[c][SW-1:CH_W]
                     + ((w_rem[c] >= (CH_W+1)'(FULL_SCALE)) ? QW'(1) : QW'(0));
            w_out[c*OUT_W +: OUT_W] = OUT_W'(w_q[c]);
        end
    end

    // Stage 5: output register.
    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_out <= w_out;
        end
    end

    assign o_tvalid = r_v5;
    assign o_tdata  = r_out;

endmodule

// File: rtl/colormap_interpolation_lut_top.sv
// A lookup passes entry position, point addresses, table read, weighting and output register.
// Throughput: one request per cycle while the output is not stalled; writes and lookups interleave.
// The point table is two copies of a one-read RAM, so both neighbours come in one read.
// Reset clears every pipeline valid bit and sets the point count to two.
// Control points hold no defined value until written; no clearing pass is made.
`timescale 1ns / 1ps
module colormap_interpolation_lut_top import cli_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_data,   // point_count
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [63:0]             i_s_tdata,    // point_index, point_red, point_green,
                                                  // point_blue, entry_index, zero fill
    input  logic                    i_s_tuser,    // func
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [NUM_CH*OUT_W-1:0] o_m_tdata     // out_red, out_green, out_blue
);

    localparam int LW = $clog2(MAX_POINTS);

    logic [LW-1:0]      r_last, n_last;
    logic               r_v3;
    logic [ENTRY_W-1:0] r_frac3;
    logic               w_en3, w_take, w_we;
    t_cli_ctl           w_ctl2;
    logic [LW-1:0]      w_left, w_right, w_waddr;
    logic [ENTRY_W-1:0] w_frac;
    logic [POINT_W-1:0] w_point, w_y0, w_y1;

    // Point count is held as its last index, clamped into the table size.
    always_comb begin
        if (i_cfg_data < CFG_W'(2)) begin
            n_last = LW'(1);
        end else if ({{(32-CFG_W){1'b0}}, i_cfg_data} > 32'(MAX_POINTS)) begin
            n_last = LW'(MAX_POINTS - 1);
        end else begin
            n_last = LW'(i_cfg_data - CFG_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= LW'(1);
        end else if (i_cfg_valid) begin
            r_last <= n_last;
        end
    end

    assign o_cfg_ready = 1'b1;

    cli_index #(
        .MAX_POINTS (MAX_POINTS)
    ) u_cli_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_func    (i_s_tuser),
        .i_slot    (i_s_tdata[5:0]),
        .i_point   (i_s_tdata[53:6]),
        .i_entry   (i_s_tdata[61:54]),
        .i_last    (r_last),
        .i_next_en (w_en3),
        .o_ready   (o_s_tready),
        .o_ctl     (w_ctl2),
        .o_left    (w_left),
        .o_right   (w_right),
        .o_frac    (w_frac),
        .o_waddr   (w_waddr),
        .o_point   (w_point)
    );

    // Stage 3: table read. A write request updates both copies as it passes here,
    // so every later lookup sees it.
    assign w_en3 = !r_v3 || w_take;
    assign w_we  = w_en3 && w_ctl2.valid && !w_ctl2.lookup && w_ctl2.wr_ok;

    cli_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_cli_ram_left (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_point),
        .i_re    (w_en3),
        .i_raddr (w_left),
        .o_rdata (w_y0)
    );

    cli_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_cli_ram_right (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_point),
        .i_re    (w_en3),
        .i_raddr (w_right),
        .o_rdata (w_y1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en3) begin
            r_v3 <= w_ctl2.valid && w_ctl2.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_frac3 <= w_frac;
        end
    end

    cli_blend u_cli_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v3),
        .i_y0     (w_y0),
        .i_y1     (w_y1),
        .i_frac   (r_frac3),
        .i_tready (i_m_tready),
        .o_take   (w_take),
        .o_tvalid (o_m_tvalid),
        .o_tdata  (o_m_tdata)
    );

endmodule

// File: rtl/cli_checker.sv
// Port-level checks of the colour map lookup, bound to the top level.
`timescale 1ns / 1ps
`include "colormap_interpolation_lut_top_macros.svh"
module cli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_cfg_ready
);

    // An empty output register means every stage may advance, so requests flow in.
    `CLI_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "input stalled with empty output")

    `CLI_ASSERT(a_valid_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    `CLI_ASSERT(a_data_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata), "result changed while stalled")

    `CLI_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid && o_cfg_ready, "output valid after reset")

endmodule

bind colormap_interpolation_lut_top cli_checker u_cli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_cfg_ready (o_cfg_ready)
);

// File: sim/testbench.sv
// Self-checking testbench for the colour map lookup: point writes, lookups and point counts.
`timescale 1ns / 1ps
module testbench import cli_pkg::*;;

    localparam int MAX_POINTS     = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 250;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 138;
    localparam int IDLE_PERCENT   = 29;

    // Request layout on tdata, lowest field first at the bottom of the struct.
    typedef struct packed {
        logic [1:0]       fill;
        logic [7:0]       entry_index;
        logic [CH_W-1:0]  point_blue;
        logic [CH_W-1:0]  point_green;
        logic [CH_W-1:0]  point_red;
        logic [SLOT_W-1:0] point_index;
    } t_request;

    typedef struct packed {
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } t_colour;

    class colormap_tracker;
        logic [CH_W-1:0] points [MAX_POINTS][NUM_CH];
        bit              written [MAX_POINTS];
        int unsigned     count;
        t_colour         expected_colours [$];
        int              failures;
        int              writes_seen;
        int              lookups_checked;

        function new();
            count = 2;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            if (v < 2)
                count = 2;
            else if (v > MAX_POINTS)
                count = MAX_POINTS;
            else
                count = v;
        endfunction

        // Lowest slot in use that has never been written, or -1 when all are valid.
        function int first_unwritten();
            for (int i = 0; i < int'(count); i++) begin
                if (!written[i])
                    return i;
            end
            return -1;
        endfunction

        function t_colour interpolate_colour(logic [7:0] entry);
            int unsigned     pos;
            int unsigned     left;
            int unsigned     right;
            int unsigned     rem;
            longint unsigned acc;
            logic [OUT_W-1:0] chan [NUM_CH];
            t_colour         c;
            pos  = entry * (count - 1);
            left = pos / STEP_DIV;
            rem  = pos % STEP_DIV;
            if (left > count - 1)
                left = count - 1;
            right = (rem != 0) ? left + 1 : left;
            if (right > count - 1)
                right = count - 1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc = longint'(STEP_DIV - rem) * points[left][ch]
                    + longint'(rem) * points[right][ch];
                chan[ch] = OUT_W'(acc / FULL_SCALE);
            end
            c.red   = chan[0];
            c.green = chan[1];
            c.blue  = chan[2];
            return c;
        endfunction

        function void note_request(logic func, t_request req);
            if (func == FUNC_WRITE) begin
                if (req.point_index < MAX_POINTS) begin
                    points[req.point_index][0] = req.point_red;
                    points[req.point_index][1] = req.point_green;
                    points[req.point_index][2] = req.point_blue;
                    written[req.point_index]   = 1'b1;
                end
                writes_seen++;
            end else begin
                expected_colours.push_back(interpolate_colour(req.entry_index));
            end
        endfunction

        function void check_colour(t_colour got);
            t_colour want;
            if (expected_colours.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result %h with no lookup outstanding", got);
                return;
            end
            want = expected_colours.pop_front();
            lookups_checked++;
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            begin
                failures++;
                if (failures <= 10)
                    $display("Colour mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             want.red, want.green, want.blue, got.red, got.green, got.blue);
            end
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    logic [63:0]             i_s_tdata   = '0;
    logic                    i_s_tuser   = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    logic [NUM_CH*OUT_W-1:0] o_m_tdata;

    colormap_tracker tracker = new();
    bit              idle_on     = 1'b1;
    bit              hold_armed  = 1'b0;
    int              quiet_cycles = 0;
    int              settings_used = 0;

    colormap_interpolation_lut_top #(
        .MAX_POINTS (MAX_POINTS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Requests and results are sampled at the edge, before any driven update lands.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            tracker.note_request(i_s_tuser, t_request'(i_s_tdata));
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_colour(t_colour'(o_m_tdata));
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Watchdog expired with %0d lookups outstanding",
                 tracker.expected_colours.size());
        $display("colormap_interpolation_lut_top test failed");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off when armed.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    function automatic logic [CH_W-1:0] random_channel();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    // Each idle cycle is drawn on its own, so the sender idles in about the set share.
    task automatic send_request(logic func, t_request req);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tuser  <= func;
        i_s_tdata  <= req;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic write_point(int slot, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                               logic [CH_W-1:0] b);
        t_request req;
        req             = '0;
        req.point_index = SLOT_W'(slot);
        req.point_red   = r;
        req.point_green = g;
        req.point_blue  = b;
        req.entry_index = 8'($urandom_range(0, 255));
        send_request(FUNC_WRITE, req);
    endtask

    task automatic lookup_entry(int entry);
        t_request req;
        req             = '0;
        req.point_index = SLOT_W'($urandom_range(0, MAX_POINTS - 1));
        req.point_red   = CH_W'($urandom_range(0, FULL_SCALE));
        req.point_green = CH_W'($urandom_range(0, FULL_SCALE));
        req.point_blue  = CH_W'($urandom_range(0, FULL_SCALE));
        req.entry_index = 8'(entry);
        send_request(FUNC_LOOKUP, req);
    endtask

    // Lowers valid once the last request has gone, then waits for every result.
    task automatic drain_lookups();
        i_s_tvalid <= 1'b0;
        while (tracker.expected_colours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_point_count(int value);
        i_cfg_data  <= CFG_W'(value);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.set_count(CFG_W'(value));
        settings_used++;
    endtask

    task automatic random_request();
        int slot;
        int entry;
        slot = tracker.first_unwritten();
        if (slot >= 0) begin
            write_point(slot, random_channel(), random_channel(), random_channel());
        end else if ($urandom_range(99) < 30) begin
            write_point($urandom_range(0, MAX_POINTS - 1), random_channel(), random_channel(),
                        random_channel());
        end else begin
            if ($urandom_range(9) == 0)
                entry = $urandom_range(1) ? 255 : 0;
            else
                entry = $urandom_range(0, 255);
            lookup_entry(entry);
        end
    endtask

    initial begin
        int phase_counts [9];
        int count_now;
        phase_counts = '{64, 127, 0, 1, 65, 2, 3, 33, 17};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two points after reset: opposite extremes, so red and blue ramp up while green ramps down.
        write_point(0, '0, '1, '0);
        write_point(1, '1, '0, '1);
        lookup_entry(0);
        lookup_entry(1);
        lookup_entry(127);
        lookup_entry(128);
        lookup_entry(254);
        lookup_entry(255);
        // A lookup right behind a write to the point it reads.
        write_point(1, 16'h8000, 16'h0001, 16'hFFFE);
        lookup_entry(255);
        drain_lookups();

        set_point_count(3);
        write_point(2, '1, '1, '1);
        lookup_entry(0);
        lookup_entry(127);
        lookup_entry(128);
        lookup_entry(255);
        drain_lookups();

        // Counts below two are taken as two.
        set_point_count(0);
        lookup_entry(255);
        drain_lookups();
        set_point_count(1);
        lookup_entry(128);
        drain_lookups();

        for (int p = 0; p < PHASES; p++) begin
            idle_on   = (p != 2);
            count_now = (p < 9) ? phase_counts[p] : $urandom_range(0, 127);
            set_point_count(count_now);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 100)
                    hold_armed = 1'b1;
                random_request();
            end
            drain_lookups();
        end
        idle_on = 1'b1;

        $display("Run covered %0d point writes and %0d checked lookups", tracker.writes_seen,
                 tracker.lookups_checked);
        $display("over %0d point-count settings, with stalls on both sides.", settings_used);
        if (tracker.failures == 0 && tracker.expected_colours.size() == 0) begin
            $display("colormap_interpolation_lut_top test passed");
        end else begin
            $display("%0d failures, %0d lookups left unanswered", tracker.failures,
                     tracker.expected_colours.size());
            $display("colormap_interpolation_lut_top test failed");
        end
        $finish;
    end

endmodule
